>>> rtl/hcbd_pkg.sv
package hcbd_pkg;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       restart;
    } item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       message_done;
        logic       format_error;
    } result_t;

    typedef enum logic [2:0] {
        CLS_CR    = 3'd0,
        CLS_LF    = 3'd1,
        CLS_SEMI  = 3'd2,
        CLS_ZERO  = 3'd3,
        CLS_HEX   = 3'd4,
        CLS_OTHER = 3'd5
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic [3:0]  digit;
        logic [7:0]  data;
        logic        restart;
    } token_t;

    localparam logic [7:0] CHAR_CR           = 8'h0D;
    localparam logic [7:0] CHAR_LF           = 8'h0A;
    localparam logic [7:0] CHAR_SEMI         = 8'h3B;
    localparam logic [7:0] CHAR_ZERO         = 8'h30;
    localparam logic [7:0] CHAR_ONE          = 8'h31;
    localparam logic [7:0] CHAR_NINE         = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F      = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A      = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F      = 8'h46;
    localparam logic [7:0] LOWER_HEX_OFFSET  = 8'd87;
    localparam logic [7:0] UPPER_HEX_OFFSET  = 8'd55;

endpackage

>>> rtl/hcbd_front.sv
module hcbd_front (
    input  hcbd_pkg::item_t  item,
    input  logic             item_valid,
    output logic             item_stall,
    output hcbd_pkg::token_t token,
    output logic             token_valid,
    input  logic             token_stall
);
    import hcbd_pkg::*;

    logic [7:0] b;
    logic [7:0] diff;

    assign b           = item.body_byte;
    assign token_valid = item_valid;
    assign item_stall  = token_stall;

    // byte classification and hex digit value
    always_comb
    begin
        token.data    = b;
        token.restart = item.restart;
        token.cls     = CLS_OTHER;
        diff          = 8'd0;
        if (b == CHAR_CR)
        begin
            token.cls = CLS_CR;
        end
        else if (b == CHAR_LF)
        begin
            token.cls = CLS_LF;
        end
        else if (b == CHAR_SEMI)
        begin
            token.cls = CLS_SEMI;
        end
        else if (b == CHAR_ZERO)
        begin
            token.cls = CLS_ZERO;
        end
        else if (b >= CHAR_ONE && b <= CHAR_NINE)
        begin
            token.cls = CLS_HEX;
            diff      = b - CHAR_ZERO;
        end
        else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F)
        begin
            token.cls = CLS_HEX;
            diff      = b - LOWER_HEX_OFFSET;
        end
        else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F)
        begin
            token.cls = CLS_HEX;
            diff      = b - UPPER_HEX_OFFSET;
        end
        token.digit = diff[3:0];
    end

endmodule

>>> rtl/hcbd_queue.sv
module hcbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  hcbd_pkg::token_t push_token,
    input  logic             push_valid,
    output logic             push_stall,
    output hcbd_pkg::token_t pop_token,
    output logic             pop_valid,
    input  logic             pop_stall
);
    import hcbd_pkg::*;

    token_t     entry_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push, pop;

    assign push_stall = (count_reg == 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_token  = entry_reg[rd_ptr_reg];
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;

    always_comb
    begin
        count_next  = count_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule

>>> rtl/hcbd_parse.sv
module hcbd_parse #(
    parameter int SIZE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hcbd_pkg::token_t  token,
    input  logic              token_valid,
    output logic              token_stall,
    output hcbd_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import hcbd_pkg::*;

    typedef enum logic [10:0] {
        PH_LEN_START = 11'b000_0000_0001,
        PH_LEN       = 11'b000_0000_0010,
        PH_LEN_EXT   = 11'b000_0000_0100,
        PH_LEN_CR    = 11'b000_0000_1000,
        PH_DATA      = 11'b000_0001_0000,
        PH_DATA_CR   = 11'b000_0010_0000,
        PH_LAST      = 11'b000_0100_0000,
        PH_LAST_CR   = 11'b000_1000_0000,
        PH_FINAL     = 11'b001_0000_0000,
        PH_FINAL_CR  = 11'b010_0000_0000,
        PH_DONE      = 11'b100_0000_0000
    } phase_t;

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [SIZE_BITS-1:0]   left_reg, left_next, left_cur;
    logic                   err_reg, err_next, err_cur;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;
    logic                   take;
    logic                   pv;
    logic                   is_digit;

    assign take         = token_valid && (!res_valid_reg || !result_stall);
    assign token_stall  = res_valid_reg && result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign is_digit     = (token.cls == CLS_HEX) || (token.cls == CLS_ZERO);

    always_comb
    begin
        phase_cur = token.restart ? PH_LEN_START : phase_reg;
        left_cur  = token.restart ? '0 : left_reg;
        err_cur   = token.restart ? 1'b0 : err_reg;

        phase_next = phase_cur;
        left_next  = left_cur;
        err_next   = err_cur;
        pv         = 1'b0;

        if (!err_cur && phase_cur != PH_DONE)
        begin
            case (phase_cur)
                PH_LEN_START:
                begin
                    if (token.cls == CLS_ZERO)
                    begin
                        phase_next = PH_LAST;
                    end
                    else if (token.cls == CLS_HEX)
                    begin
                        left_next  = {{(SIZE_BITS-4){1'b0}}, token.digit};
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_LEN:
                begin
                    if (token.cls == CLS_CR)
                    begin
                        phase_next = PH_LEN_CR;
                    end
                    else if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_DATA;
                    end
                    else if (token.cls == CLS_SEMI)
                    begin
                        phase_next = PH_LEN_EXT;
                    end
                    else if (is_digit && left_cur[SIZE_BITS-1 -: 4] == 4'd0)
                    begin
                        left_next = {left_cur[SIZE_BITS-5:0], token.digit};
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_LEN_EXT:
                begin
                    if (token.cls == CLS_CR)
                    begin
                        phase_next = PH_LEN_CR;
                    end
                    else if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_LEN_CR:
                begin
                    if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (left_cur != '0)
                    begin
                        pv        = 1'b1;
                        left_next = left_cur - 1'b1;
                    end
                    else if (token.cls == CLS_CR)
                    begin
                        phase_next = PH_DATA_CR;
                    end
                    else if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_LEN_START;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_DATA_CR:
                begin
                    if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_LEN_START;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_LAST:
                begin
                    if (token.cls == CLS_CR)
                    begin
                        phase_next = PH_LAST_CR;
                    end
                    else if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_FINAL;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_LAST_CR:
                begin
                    if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_FINAL;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_FINAL:
                begin
                    if (token.cls == CLS_CR)
                    begin
                        phase_next = PH_FINAL_CR;
                    end
                    else if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_FINAL_CR:
                begin
                    if (token.cls == CLS_LF)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        res_next.payload_valid = pv;
        res_next.payload_byte  = pv ? token.data : 8'd0;
        res_next.message_done  = (phase_next == PH_DONE);
        res_next.format_error  = err_next;

        res_valid_next = take ? 1'b1 : (res_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN_START;
            left_reg      <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take)
            begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> rtl/http_chunked_body_decoder_core.sv
// Chunked body decoder: one body byte in, one result out per transaction, at a
// sustained rate of one byte per clock while the result side does not stall.
// A byte passes through the two-entry classify queue and then the parse state
// machine's output register before it shows up on the result side. The per-byte
// parse step, including the SIZE_BITS-wide length shift or decrement, lies in
// front of that output register. A stalled result side backs up into the queue,
// and the input stalls once two bytes wait there.
module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hcbd_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_stall,
    output hcbd_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import hcbd_pkg::*;

    token_t front_token;
    logic   front_valid;
    logic   front_stall;
    token_t queue_token;
    logic   queue_valid;
    logic   queue_stall;

    hcbd_front u_front (
        .item        (item),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .token       (front_token),
        .token_valid (front_valid),
        .token_stall (front_stall)
    );

    hcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_token (front_token),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .pop_token  (queue_token),
        .pop_valid  (queue_valid),
        .pop_stall  (queue_stall)
    );

    hcbd_parse #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (queue_token),
        .token_valid  (queue_valid),
        .token_stall  (queue_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.payload_valid |->
            !result.format_error && !result.message_done)
        else $error("payload transaction with error or done set");

    a_done_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.message_done && result.format_error))
        else $error("done and error both set");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.payload_valid |-> result.payload_byte == 8'd0)
        else $error("non-payload transaction carries a byte");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        queue_valid && !queue_stall |=> !item_stall)
        else $error("input still stalled after the back end drained");

endmodule

>>> test/http_chunked_body_decoder_core_tb.sv
`timescale 1ns / 100ps

module http_chunked_body_decoder_core_tb;

    import hcbd_pkg::*;

    localparam int LEN_BITS = 32;
    localparam int STALL_PCT = 22;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES = 400;
    localparam int BURST_BYTES = 80;

    typedef enum logic [3:0] {
        PH_LEN_START,
        PH_LEN,
        PH_LEN_EXT,
        PH_LEN_CR,
        PH_DATA,
        PH_DATA_CR,
        PH_LAST,
        PH_LAST_CR,
        PH_FINAL,
        PH_FINAL_CR,
        PH_DONE
    } parse_phase_t;

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;

    parse_phase_t        phase;
    logic [LEN_BITS-1:0] chunk_left;
    logic                error_flag;

    result_t     expected_results[$];
    logic [7:0]  msg_bytes[$];
    bit          idle_on;
    int unsigned fail_count;
    int unsigned parsed_bytes;
    int unsigned sent_items;
    int unsigned messages_sent;
    int unsigned payload_seen;
    int unsigned done_seen;
    int unsigned error_seen_count;
    int unsigned quiet_cycles;

    http_chunked_body_decoder_core #(
        .SIZE_BITS(LEN_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .result(result),
        .result_valid(result_valid),
        .result_stall(result_stall)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return int'(c) - int'(CHAR_ZERO);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            return int'(c) - int'(LOWER_HEX_OFFSET);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            return int'(c) - int'(UPPER_HEX_OFFSET);
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        logic [7:0] c;
        c = (v < 10) ? CHAR_ZERO + 8'(v) : CHAR_LOWER_A + 8'(v - 10);
        if (v >= 10 && $urandom_range(1) == 1)
            c = c - (CHAR_LOWER_A - CHAR_UPPER_A);
        return c;
    endfunction

    function automatic void reset_parser();
        phase = PH_LEN_START;
        chunk_left = '0;
        error_flag = 1'b0;
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    // advances the decoder state by one byte and returns the result it should produce
    function automatic result_t decode_byte(input logic [7:0] c, input logic rs);
        result_t r;
        logic    pv;
        int      d;
        pv = 1'b0;
        if (rs)
            reset_parser();
        d = hex_digit(c);
        if (!error_flag && phase != PH_DONE)
        begin
            parsed_bytes++;
            case (phase)
                PH_LEN_START:
                    if (c == CHAR_ZERO)
                        phase = PH_LAST;
                    else if (d < 0)
                        error_flag = 1'b1;
                    else
                    begin
                        chunk_left = LEN_BITS'(d);
                        phase = PH_LEN;
                    end
                PH_LEN:
                    if (c == CHAR_CR)
                        phase = PH_LEN_CR;
                    else if (c == CHAR_LF)
                        phase = PH_DATA;
                    else if (c == CHAR_SEMI)
                        phase = PH_LEN_EXT;
                    else if (d < 0 || chunk_left[LEN_BITS-1 -: 4] != 4'd0)
                        error_flag = 1'b1;
                    else
                        chunk_left = {chunk_left[LEN_BITS-5:0], 4'(d)};
                PH_LEN_EXT:
                    if (c == CHAR_CR)
                        phase = PH_LEN_CR;
                    else if (c == CHAR_LF)
                        phase = PH_DATA;
                PH_LEN_CR:
                    if (c == CHAR_LF)
                        phase = PH_DATA;
                    else
                        error_flag = 1'b1;
                PH_DATA:
                    if (chunk_left != '0)
                    begin
                        pv = 1'b1;
                        chunk_left = chunk_left - 1'b1;
                    end
                    else if (c == CHAR_CR)
                        phase = PH_DATA_CR;
                    else if (c == CHAR_LF)
                        phase = PH_LEN_START;
                    else
                        error_flag = 1'b1;
                PH_DATA_CR:
                    if (c == CHAR_LF)
                        phase = PH_LEN_START;
                    else
                        error_flag = 1'b1;
                PH_LAST:
                    if (c == CHAR_CR)
                        phase = PH_LAST_CR;
                    else if (c == CHAR_LF)
                        phase = PH_FINAL;
                    else
                        error_flag = 1'b1;
                PH_LAST_CR:
                    if (c == CHAR_LF)
                        phase = PH_FINAL;
                    else
                        error_flag = 1'b1;
                PH_FINAL:
                    if (c == CHAR_CR)
                        phase = PH_FINAL_CR;
                    else if (c == CHAR_LF)
                        phase = PH_DONE;
                    else
                        error_flag = 1'b1;
                PH_FINAL_CR:
                    if (c == CHAR_LF)
                        phase = PH_DONE;
                    else
                        error_flag = 1'b1;
                default:
                    error_flag = 1'b1;
            endcase
        end
        r.payload_valid = pv;
        r.payload_byte = pv ? c : 8'h00;
        r.message_done = (phase == PH_DONE);
        r.format_error = error_flag;
        return r;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic rs);
        while (idle_on && $urandom_range(99) < STALL_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= '{body_byte: b, restart: rs};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        expected_results.insert(expected_results.size(), decode_byte(b, rs));
        sent_items++;
    endtask

    task automatic push_text(input string s, input bit restart_first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], restart_first && i == 0);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic append_eol();
        if ($urandom_range(1) == 1)
            append_byte(CHAR_CR);
        append_byte(CHAR_LF);
    endtask

    task automatic append_length(input int unsigned len);
        string s;
        s = $sformatf("%0h", len);
        for (int i = 0; i < s.len(); i++)
            append_byte(hex_char(hex_digit(s[i])));
    endtask

    task automatic build_message();
        int unsigned len;
        logic [7:0]  b;
        msg_bytes.delete();
        repeat ($urandom_range(0, 3))
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            append_length(len);
            if ($urandom_range(3) == 0)
            begin
                append_byte(CHAR_SEMI);
                repeat ($urandom_range(0, 4))
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == CHAR_CR || b == CHAR_LF);
                    append_byte(b);
                end
            end
            append_eol();
            repeat (len)
                append_byte(8'($urandom_range(255)));
            append_eol();
        end
        append_byte(CHAR_ZERO);
        append_eol();
        append_eol();
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            push_byte(msg_bytes[i], i == 0);
        messages_sent++;
    endtask

    task automatic send_random_message();
        int pick;
        pick = $urandom_range(99);
        build_message();
        if (pick < 70)
        begin
            // well-formed, sometimes with trailing bytes after the end
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3))
                    append_byte(8'($urandom_range(255)));
        end
        else if (pick < 80)
            msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
        else if (pick < 88)
        begin
            while (msg_bytes.size() > 1 && $urandom_range(3) != 0)
                void'(msg_bytes.pop_back());
        end
        else if (pick < 94)
        begin
            // long length line, eight digits fit and more overflow
            msg_bytes.delete();
            append_byte(hex_char($urandom_range(1, 15)));
            repeat ($urandom_range(7, 9))
                append_byte(hex_char($urandom_range(15)));
            append_eol();
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            return;
        end
        send_message();
    endtask

    task automatic test_chunk_framing();
        push_text("2;z", 1'b1);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CHAR_LF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CHAR_LF, 1'b0);
    endtask

    task automatic test_last_chunk();
        push_byte(CHAR_ZERO, 1'b0);
        push_byte(CHAR_LF, 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CHAR_LF, 1'b0);
        push_byte(CHAR_ZERO, 1'b0);
    endtask

    task automatic test_leading_zero();
        push_byte(CHAR_ZERO, 1'b1);
        push_byte(CHAR_ZERO, 1'b0);
        push_byte(CHAR_LF, 1'b0);
    endtask

    task automatic test_length_overflow();
        push_text("fFfFfFfFa", 1'b1);
        push_byte(CHAR_LF, 1'b0);
    endtask

    task automatic test_random_messages(input int unsigned target);
        int unsigned start;
        start = sent_items;
        while (sent_items - start < target)
            send_random_message();
    endtask

    task automatic test_back_to_back();
        int unsigned start;
        start = sent_items;
        idle_on = 1'b0;
        while (sent_items - start < BURST_BYTES)
        begin
            build_message();
            send_message();
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        result_stall <= idle_on && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", result);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.payload_valid !== want.payload_valid)
                begin
                    $error("payload_valid: expected %0d, got %0d",
                           want.payload_valid, result.payload_valid);
                    fail_count++;
                end
                if (result.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %02h, got %02h",
                           want.payload_byte, result.payload_byte);
                    fail_count++;
                end
                if (result.message_done !== want.message_done)
                begin
                    $error("message_done: expected %0d, got %0d",
                           want.message_done, result.message_done);
                    fail_count++;
                end
                if (result.format_error !== want.format_error)
                begin
                    $error("format_error: expected %0d, got %0d",
                           want.format_error, result.format_error);
                    fail_count++;
                end
                payload_seen += want.payload_valid;
                done_seen += want.message_done;
                error_seen_count += want.format_error;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("http_chunked_body_decoder_core verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        idle_on = 1'b1;
        fail_count = 0;
        parsed_bytes = 0;
        sent_items = 0;
        messages_sent = 0;
        payload_seen = 0;
        done_seen = 0;
        error_seen_count = 0;
        quiet_cycles = 0;
        reset_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_chunk_framing();
        test_last_chunk();
        test_leading_zero();
        test_length_overflow();
        wait_drained();
        test_random_messages(RANDOM_BYTES / 2);
        wait_drained();
        test_back_to_back();
        test_random_messages(RANDOM_BYTES / 2);
        wait_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d bytes, %0d parsed, over %0d random messages plus directed framing,",
                 sent_items, parsed_bytes, messages_sent);
        $display("with %0d payload, %0d done and %0d error results checked",
                 payload_seen, done_seen, error_seen_count);
        if (fail_count == 0)
            $display("http_chunked_body_decoder_core verification clean");
        else
            $display("http_chunked_body_decoder_core verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/hcbd_pkg.sv
rtl/hcbd_front.sv
rtl/hcbd_queue.sv
rtl/hcbd_parse.sv
rtl/http_chunked_body_decoder_core.sv
test/http_chunked_body_decoder_core_tb.sv
